### hw/rtl/rqr_pkg.sv
// Shared types and constants for the ready queue with removal.
`default_nettype none

package rqr_pkg;

  localparam int ID_W   = 16;
  localparam int WAIT_W = 16;
  localparam int OCC_W  = 7;

  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_DEQUEUE = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CO_NONE,
    CO_PUSH,
    CO_POP,
    CO_TICK
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // broadcast from the control to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [ID_W-1:0]     key;
    logic [ID_W-1:0]     new_id;
    logic [WAIT_W-1:0]   new_wait;
  } cell_ctl_t;

  // search token and captured entry, passed cell to cell
  typedef struct packed {
    logic                tok;
    logic                fnd;
    logic [ID_W-1:0]     id;
    logic [WAIT_W-1:0]   wtime;
  } link_t;

endpackage

`default_nettype wire

### hw/rtl/rqr_cell.sv
// One queue slot: holds an entry, shifts, ticks and takes part in the search walk.
`default_nettype none

module rqr_cell #(
  parameter int DEPTH = 8,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rqr_pkg::cell_ctl_t          ctl,
  input  wire logic [CW-1:0]               count,
  input  wire logic [rqr_pkg::ID_W-1:0]    nb_id,
  input  wire logic [rqr_pkg::WAIT_W-1:0]  nb_wait,
  input  wire rqr_pkg::link_t              link_in,
  output rqr_pkg::link_t                   link_out,
  output logic [rqr_pkg::ID_W-1:0]         slot_id,
  output logic [rqr_pkg::WAIT_W-1:0]       slot_wait
);

  logic                        tok;
  logic                        fnd;
  logic [rqr_pkg::ID_W-1:0]    carry_id;
  logic [rqr_pkg::WAIT_W-1:0]  carry_wait;
  logic                        occ;
  logic                        sel;
  logic                        hit;
  logic                        shift;

  assign occ   = CW'(INDEX) < count;
  assign sel   = count == CW'(INDEX);
  // first match seen by the walking token
  assign hit   = tok && !fnd && occ && (slot_id == ctl.key);
  // removed slot and everything behind it close up
  assign shift = tok && (fnd || hit);

  assign link_out.tok   = tok;
  assign link_out.fnd   = fnd || hit;
  assign link_out.id    = hit ? slot_id   : carry_id;
  assign link_out.wtime = hit ? slot_wait : carry_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
      fnd <= 1'b0;
    end else begin
      tok <= link_in.tok;
      fnd <= link_in.fnd;
    end
  end

  always_ff @(posedge clk) begin
    carry_id   <= link_in.id;
    carry_wait <= link_in.wtime;
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      rqr_pkg::CO_PUSH: begin
        if (sel) begin
          slot_id   <= ctl.new_id;
          slot_wait <= ctl.new_wait;
        end
      end
      rqr_pkg::CO_POP: begin
        slot_id   <= nb_id;
        slot_wait <= nb_wait;
      end
      rqr_pkg::CO_TICK: begin
        if (occ && (slot_wait != '1)) begin
          slot_wait <= slot_wait + rqr_pkg::WAIT_W'(1);
        end
      end
      rqr_pkg::CO_NONE: begin
        if (shift) begin
          slot_id   <= nb_id;
          slot_wait <= nb_wait;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ready_queue_with_removal.sv
// Enqueue, dequeue and tick: result registered in the cycle after the request, one request
// per cycle while no remove walks and no result stalls. Remove: a token walks the cell
// chain one slot per cycle; result registered after the last cell, no request taken
// meanwhile; a remove on an empty queue answers directly. The output register lets the
// next request in while the current result is being taken. Reset clears the entry
// count, the search tokens and the output valid; slot contents are left as they are.
`default_nettype none

module ready_queue_with_removal #(
  parameter int DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [rqr_pkg::ID_W-1:0]    proc_id,
  input  wire logic [rqr_pkg::WAIT_W-1:0]  wait_in,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [1:0]                       status,
  output logic [rqr_pkg::ID_W-1:0]         out_id,
  output logic [rqr_pkg::WAIT_W-1:0]       out_wait,
  output logic [rqr_pkg::OCC_W-1:0]        occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  rqr_pkg::state_t             state;
  rqr_pkg::state_t             state_next;
  rqr_pkg::cell_ctl_t          ctl;
  rqr_pkg::link_t              links [DEPTH+1];
  logic [rqr_pkg::ID_W-1:0]    cell_id   [DEPTH];
  logic [rqr_pkg::WAIT_W-1:0]  cell_wait [DEPTH];
  logic [CW-1:0]               count;
  logic [rqr_pkg::ID_W-1:0]    key;
  logic                        accept;
  logic                        start;
  logic                        full;
  logic                        empty;
  logic                        done;
  logic                        found;

  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;
  assign req_stall = (state == rqr_pkg::S_SCAN) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign done      = links[DEPTH].tok;
  assign found     = links[DEPTH].fnd;
  assign occupancy = rqr_pkg::OCC_W'(count);

  assign links[0] = '{tok: start, fnd: 1'b0, id: '0, wtime: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [rqr_pkg::ID_W-1:0]   nb_id;
    logic [rqr_pkg::WAIT_W-1:0] nb_wait;

    if (i < DEPTH - 1) begin : g_nb
      assign nb_id   = cell_id[i+1];
      assign nb_wait = cell_wait[i+1];
    end else begin : g_last
      assign nb_id   = '0;
      assign nb_wait = '0;
    end

    rqr_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .nb_id     (nb_id),
      .nb_wait   (nb_wait),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .slot_id   (cell_id[i]),
      .slot_wait (cell_wait[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    start        = 1'b0;
    ctl.op       = rqr_pkg::CO_NONE;
    ctl.key      = key;
    ctl.new_id   = proc_id;
    ctl.new_wait = wait_in;
    unique case (state)
      rqr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (rqr_pkg::mode_t'(mode))
            rqr_pkg::MODE_ENQUEUE: if (!full)  ctl.op = rqr_pkg::CO_PUSH;
            rqr_pkg::MODE_DEQUEUE: if (!empty) ctl.op = rqr_pkg::CO_POP;
            rqr_pkg::MODE_REMOVE: begin
              if (!empty) begin
                start      = 1'b1;
                state_next = rqr_pkg::S_SCAN;
              end
            end
            rqr_pkg::MODE_TICK:    ctl.op = rqr_pkg::CO_TICK;
          endcase
        end
      end
      rqr_pkg::S_SCAN: begin
        if (done) state_next = rqr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) key <= proc_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if ((state == rqr_pkg::S_SCAN) && done) begin
      rsp_valid <= 1'b1;
      status    <= found ? rqr_pkg::STAT_OK : rqr_pkg::STAT_NOT_FOUND;
      out_id    <= links[DEPTH].id;
      out_wait  <= links[DEPTH].wtime;
      if (found) count <= count - CW'(1);
    end else if (accept) begin
      rsp_valid <= 1'b1;
      status    <= rqr_pkg::STAT_OK;
      out_id    <= '0;
      out_wait  <= '0;
      unique case (rqr_pkg::mode_t'(mode))
        rqr_pkg::MODE_ENQUEUE: begin
          if (full) status <= rqr_pkg::STAT_FULL;
          else      count  <= count + CW'(1);
        end
        rqr_pkg::MODE_DEQUEUE: begin
          if (empty) begin
            status <= rqr_pkg::STAT_EMPTY;
          end else begin
            out_id   <= cell_id[0];
            out_wait <= cell_wait[0];
            count    <= count - CW'(1);
          end
        end
        rqr_pkg::MODE_REMOVE: begin
          if (empty) status    <= rqr_pkg::STAT_EMPTY;
          else       rsp_valid <= 1'b0;
        end
        rqr_pkg::MODE_TICK: begin
        end
      endcase
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rqr_check.sv
// Port-level checks for the ready queue with removal, bound to the top level.
`default_nettype none

module rqr_check #(
  parameter int DEPTH = 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire logic [1:0]                  status,
  input wire logic [rqr_pkg::ID_W-1:0]    out_id,
  input wire logic [rqr_pkg::WAIT_W-1:0]  out_wait,
  input wire logic [rqr_pkg::OCC_W-1:0]   occupancy
);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occupancy <= rqr_pkg::OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != rqr_pkg::STAT_OK)) |-> (out_id == '0) && (out_wait == '0))
    else $error("failed request returned an entry");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == rqr_pkg::STAT_FULL)) |-> occupancy == rqr_pkg::OCC_W'(DEPTH))
    else $error("full reported below depth");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == rqr_pkg::STAT_EMPTY)) |-> occupancy == '0)
    else $error("empty reported with entries queued");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid && $stable(status) && $stable(out_id)
                                 && $stable(out_wait) && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind ready_queue_with_removal rqr_check #(.DEPTH(DEPTH)) u_rqr_check (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the ready queue with removal: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    rqr_pkg::mode_t             op;
    logic [rqr_pkg::ID_W-1:0]   pid;
    logic [rqr_pkg::WAIT_W-1:0] wt;
  } request_t;

  typedef struct packed {
    rqr_pkg::status_t           st;
    logic [rqr_pkg::ID_W-1:0]   id;
    logic [rqr_pkg::WAIT_W-1:0] wt;
    logic [rqr_pkg::OCC_W-1:0]  occ;
  } outcome_t;

  typedef struct packed {
    logic [rqr_pkg::ID_W-1:0]   id;
    logic [rqr_pkg::WAIT_W-1:0] wt;
  } entry_t;

  typedef struct packed {
    request_t rq;
    bit       typed;
    outcome_t want;
  } row_t;

  localparam outcome_t UNTYPED = '{rqr_pkg::STAT_OK, 16'h0000, 16'h0000, 7'd0};

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  rqr_pkg::mode_t             req_mode  = rqr_pkg::MODE_TICK;
  logic [rqr_pkg::ID_W-1:0]   req_id    = '0;
  logic [rqr_pkg::WAIT_W-1:0] req_wait  = '0;
  logic                       rsp_stall = 1'b0;
  logic                       req_stall;
  logic                       rsp_valid;
  logic [1:0]                 status;
  logic [rqr_pkg::ID_W-1:0]   out_id;
  logic [rqr_pkg::WAIT_W-1:0] out_wait;
  logic [rqr_pkg::OCC_W-1:0]  occupancy;

  entry_t   held[$];        // queued processes, head first
  outcome_t outcome_due[$]; // results still owed by the block
  int       faults = 0;
  int       cycles = 0;
  bit       steady = 1'b0;  // no idling on either side while set

  // requests in issue order; saturated waits (0xFFFF) remain as a tail case
  row_t plan [25] = '{
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_EMPTY, 16'h0, 16'h0, 7'd0}},
    '{'{rqr_pkg::MODE_REMOVE,  16'hFFFF, 16'hFFFF}, 1'b1,
      '{rqr_pkg::STAT_EMPTY, 16'h0, 16'h0, 7'd0}},
    '{'{rqr_pkg::MODE_TICK,    16'h0000, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd0}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'hFFFF, 16'hFFFE}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd1}},
    '{'{rqr_pkg::MODE_TICK,    16'hFFFF, 16'hFFFF}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd1}},
    '{'{rqr_pkg::MODE_TICK,    16'h5A5A, 16'hA5A5}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd1}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h0000, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd2}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h1234, 16'hFFFF}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd3}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h1234, 16'h0005}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd4}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'hAAAA, 16'h5555}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd5}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h5555, 16'hAAAA}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd6}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h0007, 16'h0007}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd7}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h0008, 16'h0008}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd8}},
    '{'{rqr_pkg::MODE_ENQUEUE, 16'h0009, 16'h0009}, 1'b1,
      '{rqr_pkg::STAT_FULL, 16'h0, 16'h0, 7'd8}},
    '{'{rqr_pkg::MODE_TICK,    16'h0000, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_OK, 16'h0, 16'h0, 7'd8}},
    '{'{rqr_pkg::MODE_REMOVE,  16'hBEEF, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_NOT_FOUND, 16'h0, 16'h0, 7'd8}},
    '{'{rqr_pkg::MODE_REMOVE,  16'h1234, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_REMOVE,  16'h1234, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_REMOVE,  16'h0008, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_REMOVE,  16'h0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{rqr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000}, 1'b1,
      '{rqr_pkg::STAT_EMPTY, 16'h0, 16'h0, 7'd0}}
  };

  ready_queue_with_removal #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (req_mode),
    .proc_id   (req_id),
    .wait_in   (req_wait),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .out_id    (out_id),
    .out_wait  (out_wait),
    .occupancy (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the scheduler model and return the result it owes.
  function automatic outcome_t apply_op(request_t r);
    outcome_t o;
    int       pos;
    o   = UNTYPED;
    pos = -1;
    case (r.op)
      rqr_pkg::MODE_ENQUEUE: begin
        if (held.size() >= DEPTH) o.st = rqr_pkg::STAT_FULL;
        else held.push_back(entry_t'{r.pid, r.wt});
      end
      rqr_pkg::MODE_DEQUEUE: begin
        if (held.size() == 0) begin
          o.st = rqr_pkg::STAT_EMPTY;
        end else begin
          o.id = held[0].id;
          o.wt = held[0].wt;
          void'(held.pop_front());
        end
      end
      rqr_pkg::MODE_REMOVE: begin
        if (held.size() == 0) begin
          o.st = rqr_pkg::STAT_EMPTY;
        end else begin
          foreach (held[k]) if (pos < 0 && held[k].id == r.pid) pos = k;
          if (pos < 0) begin
            o.st = rqr_pkg::STAT_NOT_FOUND;
          end else begin
            o.id = held[pos].id;
            o.wt = held[pos].wt;
            held.delete(pos);
          end
        end
      end
      default: begin
        foreach (held[k]) if (held[k].wt != 16'hFFFF) held[k].wt = held[k].wt + 16'd1;
      end
    endcase
    o.occ = rqr_pkg::OCC_W'(held.size());
    return o;
  endfunction

  // Mostly valid traffic: removes usually name a queued process, some ids repeat.
  function automatic request_t draw_request(bit filling);
    request_t r;
    int       roll;
    int       enq_pct;
    int       deq_pct;
    enq_pct = filling ? 45 : 20;
    deq_pct = filling ? 15 : 35;
    roll    = $urandom_range(0, 99);
    r.pid   = 16'($urandom);
    r.wt    = 16'($urandom);
    if (roll < enq_pct) begin
      r.op = rqr_pkg::MODE_ENQUEUE;
      case ($urandom_range(0, 9))
        0, 1, 2: r.pid = 16'($urandom_range(0, 3));
        3: if (held.size() != 0) r.pid = held[$urandom_range(0, held.size() - 1)].id;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1: r.wt = 16'hFFFF - 16'($urandom_range(0, 3));
        2: r.wt = '0;
        default: ;
      endcase
    end else if (roll < enq_pct + deq_pct) begin
      r.op = rqr_pkg::MODE_DEQUEUE;
    end else if (roll < enq_pct + deq_pct + 25) begin
      r.op = rqr_pkg::MODE_REMOVE;
      if (held.size() != 0 && $urandom_range(0, 3) != 0)
        r.pid = held[$urandom_range(0, held.size() - 1)].id;
    end else begin
      r.op = rqr_pkg::MODE_TICK;
    end
    return r;
  endfunction

  // Present one request, hold it until taken, then book its result.
  task automatic issue(request_t r, bit typed, outcome_t want);
    outcome_t pred;
    while (!steady && $urandom_range(0, 99) < 25) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_mode  <= r.op;
    req_id    <= r.pid;
    req_wait  <= r.wt;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = apply_op(r);
    outcome_due.push_back(typed ? want : pred);
  endtask

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_due.size() == 0) begin
        $display("%0t: unexpected result status %0d id %h wait %h occupancy %0d",
                 $time, status, out_id, out_wait, occupancy);
        faults++;
      end else begin
        exp_o = outcome_due.pop_front();
        check_field("status", exp_o.st, status);
        check_field("out_id", exp_o.id, out_id);
        check_field("out_wait", exp_o.wt, out_wait);
        check_field("occupancy", exp_o.occ, occupancy);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int n;
    bit filling;
    filling = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) issue(plan[i].rq, plan[i].typed, plan[i].want);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) filling = $urandom_range(0, 1);
      steady = (n >= 400 && n < 600);
      issue(draw_request(filling), 1'b0, UNTYPED);
    end
    req_valid <= 1'b0;
    steady = 1'b0;
    while (outcome_due.size() != 0) @(posedge clk);
    // a remove walks the whole chain; leave room for any stray result
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (faults == 0 && outcome_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
